// File: sv/bdga_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdga_pkg
// Shared constants, types and the exp lookup table of the dose grid block.
// ----------------------------------------------------------------------------
package bdga_pkg;

  localparam int GRID_POINTS     = 64;
  localparam int GP_LOG2         = $clog2(GRID_POINTS);
  localparam int IW              = GP_LOG2;
  localparam int CELLS           = GRID_POINTS * GRID_POINTS;
  localparam int AW              = $clog2(CELLS);
  localparam int EXP_TABLE_DEPTH = 256;
  localparam int IDX_W           = $clog2(EXP_TABLE_DEPTH);

  localparam int MAP_IDX_W  = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int COORD_W    = 32;
  localparam int REG_W      = 31;
  localparam int DOSE_W     = 48;
  localparam int XW         = 34;
  localparam int SQ_W       = 2 * REG_W;
  localparam int DIVS_W     = SQ_W + 1;
  localparam int B16_W      = SQ_W + 5;
  localparam int RW         = DIVS_W + IDX_W;
  localparam int G_W        = SQ_W - 16;
  localparam int TAB_W      = 17;
  localparam int VAL_W      = G_W + TAB_W - 16;
  localparam int INC_W      = 63;
  localparam int QDEPTH     = 2;

  localparam logic [REG_W-1:0]  GAIN_NUM   = 31'd1713444048;
  localparam logic [63:0]       EXP_M1_Q32 = 64'd1580030169;
  localparam logic [DOSE_W-1:0] DOSE_MAX   = '1;

  localparam logic             RST_BEAM_TYPE      = 1'b0;
  localparam logic [REG_W-1:0] RST_GRID_RADIUS    = 31'd9830;
  localparam logic [REG_W-1:0] RST_BEAM_RADIUS    = 31'd65536;
  localparam logic [REG_W-1:0] RST_BEAM_INTENSITY = 31'd131072;
  localparam logic [REG_W-1:0] RST_TIME_STEP      = 31'd655;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BEAM_TYPE      = 3'd0,
    REG_GRID_RADIUS    = 3'd1,
    REG_BEAM_RADIUS    = 3'd2,
    REG_BEAM_INTENSITY = 3'd3,
    REG_TIME_STEP      = 3'd4
  } reg_e;

  typedef enum logic {
    CMD_EXPOSE = 1'b0,
    CMD_READ   = 1'b1
  } cmd_e;

  typedef enum logic {
    KIND_STEP = 1'b0,
    KIND_READ = 1'b1
  } kind_e;

  typedef struct packed {
    cmd_e                        op;
    logic signed [COORD_W-1:0]   bx;
    logic signed [COORD_W-1:0]   by;
    logic [AW-1:0]               addr;
    logic                        in_range;
  } cmd_t;

  typedef struct packed {
    logic              gauss;
    logic [REG_W-1:0]  grid_radius;
    logic [COORD_W-1:0] spacing;
    logic [SQ_W-1:0]   r2;
    logic [SQ_W-1:0]   br2;
    logic [DIVS_W-1:0] b2;
    logic [B16_W-1:0]  b16;
    logic [REG_W-1:0]  intensity;
    logic [REG_W-1:0]  time_step;
    logic [G_W-1:0]    gain;
  } param_t;

  typedef logic [TAB_W-1:0] exp_tab_t [EXP_TABLE_DEPTH];

  function automatic logic [TAB_W-1:0] exp_entry(int unsigned k);
    logic [63:0] a;
    logic [63:0] n;
    logic [63:0] f;
    logic [63:0] term;
    logic [63:0] v;
    longint      sum;
    a    = (64'(16 * k) << 32) / EXP_TABLE_DEPTH;
    n    = a >> 32;
    f    = a & 64'hFFFF_FFFF;
    term = 64'd1 << 32;
    sum  = longint'(term);
    for (int m = 1; m <= 24; m++) begin
      term = ((term * f) >> 32) / 64'(m);
      if (m % 2 == 1) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    v = (sum < 0) ? 64'd0 : 64'(sum);
    for (int c = 0; c < 16; c++) begin
      if (64'(c) < n) v = (v * EXP_M1_Q32 + (64'd1 << 31)) >> 32;
    end
    v = (v + 64'd32768) >> 16;
    return v[TAB_W-1:0];
  endfunction

  function automatic exp_tab_t build_exp_tab();
    exp_tab_t t;
    for (int k = 0; k < EXP_TABLE_DEPTH; k++) t[k] = exp_entry(k);
    return t;
  endfunction

  localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage

// File: sv/bdga_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdga channel interfaces
// Command, result and register write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bdga_item_if;
  logic                                valid;
  logic                                ready;
  logic                                cmd;
  logic signed [bdga_pkg::COORD_W-1:0] beam_x;
  logic signed [bdga_pkg::COORD_W-1:0] beam_y;
  logic [bdga_pkg::MAP_IDX_W-1:0]      map_index;
  modport source (output valid, cmd, beam_x, beam_y, map_index, input ready);
  modport sink (input valid, cmd, beam_x, beam_y, map_index, output ready);
endinterface

interface bdga_result_if;
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic [bdga_pkg::DOSE_W-1:0]  dose;
  modport source (output valid, kind, dose, input ready);
  modport sink (input valid, kind, dose, output ready);
endinterface

interface bdga_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [bdga_pkg::CFG_IDX_W-1:0]   index;
  logic [bdga_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: sv/bdga_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdga_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bdga_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: sv/bdga_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdga_cfg
// Register file and derivation of beam constants (gain divider, squares).
// ----------------------------------------------------------------------------
module bdga_cfg (
  input  logic               clk_i,
  input  logic               rst_ni,
  bdga_cfg_if.sink           cfg_i,
  output bdga_pkg::param_t   prm_o,
  output logic               busy_o
);

  localparam int GAIN_BITS = bdga_pkg::REG_W;
  localparam int CW        = $clog2(GAIN_BITS);

  typedef enum logic [1:0] {
    D_DIV,
    D_MUL,
    D_GAIN,
    D_IDLE
  } drv_state_e;

  drv_state_e                  st_q;
  logic [CW-1:0]               cnt_q;
  logic [bdga_pkg::REG_W-1:0]  rem_q, rem_d;
  logic [bdga_pkg::REG_W-1:0]  quot_q;
  logic [bdga_pkg::SQ_W-1:0]   r2_q, br2_q, bsq_q;
  logic [bdga_pkg::G_W-1:0]    g_q;
  logic                        bt_q;
  logic [bdga_pkg::REG_W-1:0]  gr_q, br_q, bi_q, ts_q;
  logic [bdga_pkg::REG_W-1:0]  dv;
  logic [bdga_pkg::REG_W:0]    remsh;
  logic                        qbit;
  logic [bdga_pkg::SQ_W-1:0]   gprod;
  logic                        wr;

  assign cfg_i.ready = 1'b1;
  assign wr          = cfg_i.valid & cfg_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bt_q <= bdga_pkg::RST_BEAM_TYPE;
      gr_q <= bdga_pkg::RST_GRID_RADIUS;
      br_q <= bdga_pkg::RST_BEAM_RADIUS;
      bi_q <= bdga_pkg::RST_BEAM_INTENSITY;
      ts_q <= bdga_pkg::RST_TIME_STEP;
    end else if (wr) begin
      case (cfg_i.index)
        bdga_pkg::REG_BEAM_TYPE:      bt_q <= cfg_i.data[0];
        bdga_pkg::REG_GRID_RADIUS:    gr_q <= cfg_i.data[bdga_pkg::REG_W-1:0];
        bdga_pkg::REG_BEAM_RADIUS:    br_q <= cfg_i.data[bdga_pkg::REG_W-1:0];
        bdga_pkg::REG_BEAM_INTENSITY: bi_q <= cfg_i.data[bdga_pkg::REG_W-1:0];
        bdga_pkg::REG_TIME_STEP:      ts_q <= cfg_i.data[bdga_pkg::REG_W-1:0];
        default: ;
      endcase
    end
  end

  assign dv    = (br_q == '0) ? bdga_pkg::REG_W'(1) : br_q;
  assign remsh = {rem_q, bdga_pkg::GAIN_NUM[CW'(GAIN_BITS - 1) - cnt_q]};
  assign qbit  = (remsh >= {1'b0, dv});
  assign rem_d = qbit ? bdga_pkg::REG_W'(remsh - {1'b0, dv}) : remsh[bdga_pkg::REG_W-1:0];
  assign gprod = bi_q * quot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= D_DIV;
      cnt_q  <= '0;
      rem_q  <= '0;
      quot_q <= '0;
      r2_q   <= '0;
      br2_q  <= '0;
      bsq_q  <= '0;
      g_q    <= '0;
    end else if (wr) begin
      st_q   <= D_DIV;
      cnt_q  <= '0;
      rem_q  <= '0;
      quot_q <= '0;
    end else begin
      case (st_q)
        D_DIV: begin
          rem_q  <= rem_d;
          quot_q <= {quot_q[bdga_pkg::REG_W-2:0], qbit};
          cnt_q  <= cnt_q + 1'b1;
          if (cnt_q == CW'(GAIN_BITS - 1)) st_q <= D_MUL;
        end
        D_MUL: begin
          r2_q  <= gr_q * gr_q;
          br2_q <= br_q * br_q;
          bsq_q <= dv * dv;
          st_q  <= D_GAIN;
        end
        D_GAIN: begin
          g_q  <= gprod[bdga_pkg::SQ_W-1:16];
          st_q <= D_IDLE;
        end
        default: ;
      endcase
    end
  end

  assign busy_o = (st_q != D_IDLE);

  always_comb begin
    prm_o             = '0;
    prm_o.gauss       = bt_q;
    prm_o.grid_radius = gr_q;
    prm_o.spacing     = bdga_pkg::COORD_W'({gr_q, 1'b0} >> bdga_pkg::GP_LOG2);
    prm_o.r2          = r2_q;
    prm_o.br2         = br2_q;
    prm_o.b2          = {bsq_q, 1'b0};
    prm_o.b16         = {bsq_q, 5'b0};
    prm_o.intensity   = bi_q;
    prm_o.time_step   = ts_q;
    prm_o.gain        = g_q;
  end

endmodule

// File: sv/bdga_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdga_front
// Accepts commands, decodes them and queues them for the execution side.
// ----------------------------------------------------------------------------
module bdga_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  bdga_item_if.sink        in_i,
  input  logic             hold_i,
  output bdga_pkg::cmd_t   cmd_o,
  output logic             cmd_valid_o,
  input  logic             cmd_pop_i
);

  bdga_pkg::cmd_t q_q [bdga_pkg::QDEPTH];
  logic           wp_q, rp_q;
  logic [1:0]     cnt_q;
  logic           push;
  logic [31:0]    idx_ext;
  bdga_pkg::cmd_t dec;

  assign in_i.ready = (cnt_q != 2'(bdga_pkg::QDEPTH)) && !hold_i;
  assign push       = in_i.valid && in_i.ready;
  assign idx_ext    = 32'(in_i.map_index);

  always_comb begin
    dec          = '0;
    dec.op       = bdga_pkg::cmd_e'(in_i.cmd);
    dec.bx       = in_i.beam_x;
    dec.by       = in_i.beam_y;
    dec.addr     = idx_ext[bdga_pkg::AW-1:0];
    dec.in_range = (idx_ext < 32'(bdga_pkg::CELLS));
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_q[wp_q] <= dec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (cmd_pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(cmd_pop_i);
    end
  end

  assign cmd_o       = q_q[rp_q];
  assign cmd_valid_o = (cnt_q != '0);

endmodule

// File: sv/bdga_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdga_back
// Grid sweep pipeline with read-modify-write of the dose map, cell reads,
// clearing pass and result register.
// ----------------------------------------------------------------------------
module bdga_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  bdga_pkg::param_t prm_i,
  input  bdga_pkg::cmd_t   cmd_i,
  input  logic             cmd_valid_i,
  output logic             cmd_pop_o,
  output logic             clearing_o,
  bdga_result_if.source    out_o
);

  localparam int XW     = bdga_pkg::XW;
  localparam int AW     = bdga_pkg::AW;
  localparam int PIPE_N = bdga_pkg::IDX_W + 9;

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_SWEEP,
    B_DRAIN,
    B_READ,
    B_RDATA
  } back_state_e;

  typedef struct packed {
    logic [AW-1:0] addr;
    logic          far;
    logic          in_tgt;
    logic          hitc;
    logic          gz;
  } ctl_t;

  back_state_e                   st_q;
  bdga_pkg::cmd_t                cmd_q;
  logic [AW-1:0]                 clr_q;
  logic [bdga_pkg::IW-1:0]       i_q, j_q;
  logic [AW-1:0]                 addr_q;
  logic signed [XW-1:0]          x_q, y_q;
  logic                          out_vld_q;
  logic                          out_kind_q;
  logic [bdga_pkg::DOSE_W-1:0]   out_dose_q;

  logic signed [XW-1:0]          neg_r, sp_s, dx, dy;
  logic [XW-1:0]                 ax, ay, adx, ady;
  logic                          far_pt;
  logic                          sweep_last, pipe_busy;

  logic [PIPE_N-1:0]             vld_q;
  ctl_t c1_q, c2_q, c3_q, c4_q, ct_q, cm_q, cv_q, ci_q, cs_q;
  ctl_t cd_q [bdga_pkg::IDX_W];

  logic [31:0]                   ax1_q, ay1_q;
  logic [bdga_pkg::REG_W-1:0]    mx1_q, my1_q;
  logic [63:0]                   ax2_q, ay2_q;
  logic [bdga_pkg::SQ_W-1:0]     mx2_q, my2_q;
  logic [64:0]                   t3_q;
  logic [bdga_pkg::DIVS_W-1:0]   d3_q;
  logic [bdga_pkg::RW-1:0]       rem4_q;
  logic [bdga_pkg::RW-1:0]       rem_s_q [bdga_pkg::IDX_W];
  logic [bdga_pkg::IDX_W-1:0]    quo_s_q [bdga_pkg::IDX_W];
  logic [bdga_pkg::TAB_W-1:0]    tv_q;
  logic [bdga_pkg::VAL_W-1:0]    gv_q, val_q;
  logic [bdga_pkg::INC_W-2:0]    hi_q;
  logic [bdga_pkg::VAL_W-1:0]    lo_q;
  logic [bdga_pkg::INC_W-1:0]    inc_q;
  logic [bdga_pkg::G_W+bdga_pkg::TAB_W-1:0] gprod;

  logic                          ram_we;
  logic [AW-1:0]                 ram_waddr, ram_raddr;
  logic [bdga_pkg::DOSE_W-1:0]   ram_wdata, ram_rdata;
  logic [bdga_pkg::DOSE_W-1:0]   room, cell_new;
  logic                          sat;

  assign neg_r      = -$signed({{(XW - bdga_pkg::REG_W){1'b0}}, prm_i.grid_radius});
  assign sp_s       = $signed({{(XW - bdga_pkg::COORD_W){1'b0}}, prm_i.spacing});
  assign sweep_last = (i_q == bdga_pkg::IW'(bdga_pkg::GRID_POINTS - 1))
                   && (j_q == bdga_pkg::IW'(bdga_pkg::GRID_POINTS - 1));
  assign cmd_pop_o  = (st_q == B_IDLE) && cmd_valid_i && !out_vld_q;
  assign clearing_o = (st_q == B_CLEAR);
  assign pipe_busy  = |vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= B_CLEAR;
      clr_q      <= '0;
      i_q        <= '0;
      j_q        <= '0;
      addr_q     <= '0;
      x_q        <= '0;
      y_q        <= '0;
      cmd_q      <= '0;
      out_vld_q  <= 1'b0;
      out_kind_q <= bdga_pkg::KIND_STEP;
      out_dose_q <= '0;
    end else begin
      if (out_vld_q && out_o.ready) out_vld_q <= 1'b0;
      case (st_q)
        B_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == '1) st_q <= B_IDLE;
        end
        B_IDLE: begin
          if (cmd_pop_o) begin
            cmd_q  <= cmd_i;
            i_q    <= '0;
            j_q    <= '0;
            addr_q <= '0;
            x_q    <= neg_r;
            y_q    <= neg_r;
            st_q   <= (cmd_i.op == bdga_pkg::CMD_READ) ? B_READ : B_SWEEP;
          end
        end
        B_SWEEP: begin
          addr_q <= addr_q + 1'b1;
          if (j_q == bdga_pkg::IW'(bdga_pkg::GRID_POINTS - 1)) begin
            j_q <= '0;
            y_q <= neg_r;
            i_q <= i_q + 1'b1;
            x_q <= x_q + sp_s;
          end else begin
            j_q <= j_q + 1'b1;
            y_q <= y_q + sp_s;
          end
          if (sweep_last) st_q <= B_DRAIN;
        end
        B_DRAIN: begin
          if (!pipe_busy) begin
            out_vld_q  <= 1'b1;
            out_kind_q <= bdga_pkg::KIND_STEP;
            out_dose_q <= '0;
            st_q       <= B_IDLE;
          end
        end
        B_READ: begin
          st_q <= B_RDATA;
        end
        B_RDATA: begin
          out_vld_q  <= 1'b1;
          out_kind_q <= bdga_pkg::KIND_READ;
          out_dose_q <= cmd_q.in_range ? ram_rdata : '0;
          st_q       <= B_IDLE;
        end
        default: st_q <= B_IDLE;
      endcase
    end
  end

  assign ax     = x_q[XW-1] ? XW'(-x_q) : XW'(x_q);
  assign ay     = y_q[XW-1] ? XW'(-y_q) : XW'(y_q);
  assign dx     = x_q - XW'(cmd_q.bx);
  assign dy     = y_q - XW'(cmd_q.by);
  assign adx    = dx[XW-1] ? XW'(-dx) : XW'(dx);
  assign ady    = dy[XW-1] ? XW'(-dy) : XW'(dy);
  assign far_pt = (adx[XW-1:bdga_pkg::REG_W] != '0) || (ady[XW-1:bdga_pkg::REG_W] != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[PIPE_N-2:0], (st_q == B_SWEEP)};
    end
  end

  assign gprod = prm_i.gain * tv_q;

  always_ff @(posedge clk_i) begin
    c1_q  <= {addr_q, far_pt, 3'b000};
    ax1_q <= ax[31:0];
    ay1_q <= ay[31:0];
    mx1_q <= adx[bdga_pkg::REG_W-1:0];
    my1_q <= ady[bdga_pkg::REG_W-1:0];

    c2_q  <= c1_q;
    ax2_q <= ax1_q * ax1_q;
    ay2_q <= ay1_q * ay1_q;
    mx2_q <= mx1_q * mx1_q;
    my2_q <= my1_q * my1_q;

    c3_q <= c2_q;
    t3_q <= {1'b0, ax2_q} + {1'b0, ay2_q};
    d3_q <= {1'b0, mx2_q} + {1'b0, my2_q};

    c4_q   <= {c3_q.addr, c3_q.far,
               (t3_q < {3'b0, prm_i.r2}),
               (!c3_q.far && (d3_q < {1'b0, prm_i.br2})),
               (c3_q.far || ({4'b0, d3_q} >= prm_i.b16))};
    rem4_q <= bdga_pkg::RW'(d3_q) << (bdga_pkg::IDX_W - 4);

    cd_q[0] <= c4_q;
    for (int s = 1; s < bdga_pkg::IDX_W; s++) begin
      cd_q[s] <= cd_q[s-1];
    end

    ct_q <= cd_q[bdga_pkg::IDX_W-1];
    tv_q <= bdga_pkg::EXP_TAB[quo_s_q[bdga_pkg::IDX_W-1]];

    cm_q <= ct_q;
    gv_q <= gprod[bdga_pkg::G_W+bdga_pkg::TAB_W-1:16];

    cv_q <= cm_q;
    if (prm_i.gauss) val_q <= cm_q.gz ? '0 : gv_q;
    else val_q <= cm_q.hitc ? bdga_pkg::VAL_W'(prm_i.intensity) : '0;

    ci_q <= cv_q;
    hi_q <= val_q[bdga_pkg::VAL_W-1:16] * prm_i.time_step;
    lo_q <= val_q[15:0] * prm_i.time_step;

    cs_q  <= ci_q;
    inc_q <= {1'b0, hi_q} + bdga_pkg::INC_W'(lo_q[bdga_pkg::VAL_W-1:16]);
  end

  // restoring division, one quotient bit per stage, MSB first
  always_ff @(posedge clk_i) begin
    for (int s = 0; s < bdga_pkg::IDX_W; s++) begin
      logic [bdga_pkg::RW-1:0]    rin;
      logic [bdga_pkg::IDX_W-1:0] qin;
      logic [bdga_pkg::RW-1:0]    dsh;
      rin = (s == 0) ? rem4_q : rem_s_q[(s == 0) ? 0 : s-1];
      qin = (s == 0) ? '0 : quo_s_q[(s == 0) ? 0 : s-1];
      dsh = bdga_pkg::RW'(prm_i.b2) << (bdga_pkg::IDX_W - 1 - s);
      if (rin >= dsh) begin
        rem_s_q[s] <= rin - dsh;
        quo_s_q[s] <= qin | (bdga_pkg::IDX_W'(1) << (bdga_pkg::IDX_W - 1 - s));
      end else begin
        rem_s_q[s] <= rin;
        quo_s_q[s] <= qin;
      end
    end
  end

  assign room     = bdga_pkg::DOSE_MAX - ram_rdata;
  assign sat      = (inc_q >= bdga_pkg::INC_W'(room));
  assign cell_new = sat ? bdga_pkg::DOSE_MAX : (ram_rdata + inc_q[bdga_pkg::DOSE_W-1:0]);

  always_comb begin
    if (st_q == B_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_q;
      ram_wdata = '0;
    end else begin
      ram_we    = vld_q[PIPE_N-1] && cs_q.in_tgt;
      ram_waddr = cs_q.addr;
      ram_wdata = cell_new;
    end
  end

  assign ram_raddr = (st_q == B_READ) ? cmd_q.addr : ci_q.addr;

  bdga_ram #(
    .WIDTH (bdga_pkg::DOSE_W),
    .DEPTH (bdga_pkg::CELLS)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_o.valid = out_vld_q;
  assign out_o.kind  = out_kind_q;
  assign out_o.dose  = out_dose_q;

endmodule

// File: sv/beam_dose_grid_accumulator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// beam_dose_grid_accumulator_core
// Dose accumulation over a 64 x 64 grid covering the target circle.
// ----------------------------------------------------------------------------
// An expose command walks all grid cells through a pipelined datapath with
// one read-modify-write of the dose RAM per cycle, and its acknowledge
// appears once all 4096 cells have passed and the pipeline has drained; a
// read command returns the dose of its cell. Commands are taken into a
// two-entry queue and run one at a time. After reset the dose RAM is zeroed
// by a clearing pass over all 4096 cells, and after reset or any register
// write a derivation of the beam constants runs; no command is accepted
// during either.
module beam_dose_grid_accumulator_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  bdga_item_if.sink     in_i,
  bdga_result_if.source out_o,
  bdga_cfg_if.sink      cfg_i
);

  bdga_pkg::param_t prm;
  bdga_pkg::cmd_t   cmd;
  logic             cfg_busy, clearing, cmd_valid, cmd_pop;

  bdga_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .prm_o  (prm),
    .busy_o (cfg_busy)
  );

  bdga_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .hold_i      (cfg_busy | clearing),
    .cmd_o       (cmd),
    .cmd_valid_o (cmd_valid),
    .cmd_pop_i   (cmd_pop)
  );

  bdga_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .prm_i       (prm),
    .cmd_i       (cmd),
    .cmd_valid_i (cmd_valid),
    .cmd_pop_o   (cmd_pop),
    .clearing_o  (clearing),
    .out_o       (out_o)
  );

endmodule

// File: sv/bdga_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdga_checker
// Port-level checks of the dose grid block, bound to the top level.
// ----------------------------------------------------------------------------
module bdga_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic                        out_kind_i,
  input logic [bdga_pkg::DOSE_W-1:0] out_dose_i
);

  logic [2:0] pend_q;
  logic       in_xfer, out_xfer;

  assign in_xfer  = in_valid_i && in_ready_i;
  assign out_xfer = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 3'(in_xfer) - 3'(out_xfer);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_dose_i) && $stable(out_kind_i))
    else $error("result dropped or changed while stalled");

  a_ack_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_kind_i == bdga_pkg::KIND_STEP) |-> (out_dose_i == '0))
    else $error("exposure acknowledge carries nonzero dose");

  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (pend_q != '0))
    else $error("result without a pending command");

  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= 3'd3)
    else $error("more commands in flight than the queue holds");

endmodule

bind beam_dose_grid_accumulator_core bdga_checker u_bdga_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_kind_i  (out_o.kind),
  .out_dose_i  (out_o.dose)
);
